[sv/assert_macros.svh]
// Assertion macros used by the checker file kts_checker.sv.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define KTS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("kts assertion failed");

// Clocked assertion that also holds during reset.
`define KTS_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("kts assertion failed");

`endif

[sv/kts_pkg.sv]
// Types, constants and state codes for the kinetic touch scroll block.
// No dependencies; used by every module of the block.
package kts_pkg;

   localparam int LIST_CAPACITY = 64;

   localparam int COUNT_W   = 7;
   localparam int OFFSET_W  = 13;
   localparam int SPEED_W   = 9;
   localparam int Y_W       = 8;
   localparam int DRAWN_W   = 14;
   localparam int CONTENT_W = 14;   // holds 127 * 83
   localparam int DVD_W     = 22;   // max_off * 190 fits
   localparam int DIVR_W    = CONTENT_W;
   localparam int STEP_W    = $clog2(DVD_W + 1);

   localparam logic [COUNT_W-1:0] CAP_CLIP =
      COUNT_W'((LIST_CAPACITY > 127) ? 127 : LIST_CAPACITY);

   localparam logic [CONTENT_W-1:0] PITCH     = CONTENT_W'(83);
   localparam logic [CONTENT_W-1:0] VIEW      = CONTENT_W'(210);
   localparam logic [Y_W-1:0]       HEADER    = Y_W'(30);
   localparam logic [7:0]           BAR_MIN   = 8'd20;
   localparam logic [7:0]           VIEW_8    = 8'd210;
   localparam logic [DVD_W-1:0]     VIEW_SQ   = DVD_W'(44100);
   localparam logic [DRAWN_W-1:0]   DRAWN_NONE = '1;

   localparam logic [STEP_W-1:0] STEPS_LONG  = STEP_W'(DVD_W);
   localparam logic [STEP_W-1:0] STEPS_SHORT = STEP_W'(16);

   // x/83 = (x * 6317) >> 19, exact for 13-bit x
   localparam logic [12:0] RECIP_PITCH = 13'd6317;
   localparam int          RECIP_PITCH_SH = 19;
   // (m*23)/25 = (m * 120589) >> 17, exact for 9-bit m
   localparam logic [16:0] DECAY_MUL = 17'd120589;
   localparam int          DECAY_SH  = 17;

   localparam logic [1:0] TOUCH_PRESS = 2'd1;

   typedef struct packed {
      logic [1:0] touch_state;
      logic [7:0] touch_y;
   } kts_req_type;

   typedef struct packed {
      logic [12:0] offset_now;
      logic        needs_redraw;
      logic        drag_active;
      logic [5:0]  first_visible;
      logic        bar_shown;
      logic [7:0]  bar_top;
      logic [7:0]  bar_length;
   } kts_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LIMITS,
      ST_TOUCH,
      ST_COAST,
      ST_MARK,
      ST_WAIT_LEN,
      ST_PROD,
      ST_TOP_START,
      ST_WAIT_TOP,
      ST_FINISH
   } kts_state_type;

   typedef struct packed {
      logic capture;
      logic limits;
      logic touch;
      logic coast;
      logic div_len_start;
      logic mark;
      logic take_len;
      logic prod;
      logic div_top_start;
      logic load_rsp;
   } kts_cmd_type;

   typedef struct packed {
      logic div_busy;
   } kts_stat_type;

endpackage

[sv/kts_div.sv]
// Restoring divider, one quotient bit per cycle, shared by the bar maths.
// Depends on kts_pkg.
module kts_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       short_mode,
   input  logic [kts_pkg::DVD_W-1:0]  dividend,
   input  logic [kts_pkg::DIVR_W-1:0] divisor,
   output logic                       busy,
   output logic [kts_pkg::DVD_W-1:0]  quotient
);
   import kts_pkg::*;

   logic [STEP_W-1:0] steps_ff, steps_in;
   logic [DVD_W-1:0]  dvd_ff, dvd_in;
   logic [DIVR_W-1:0] rem_ff, rem_in;
   logic [DIVR_W-1:0] divr_ff, divr_in;
   logic [DIVR_W:0]   rem_sh;
   logic              ge;

   always_comb begin
      rem_sh   = {rem_ff, dvd_ff[DVD_W-1]};
      ge       = rem_sh >= {1'b0, divr_ff};
      steps_in = steps_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      divr_in  = divr_ff;
      if (start) begin
         divr_in = divisor;
         rem_in  = '0;
         if (short_mode) begin
            // left-align a 16-bit dividend
            dvd_in   = dividend << (DVD_W - 16);
            steps_in = STEPS_SHORT;
         end else begin
            dvd_in   = dividend;
            steps_in = STEPS_LONG;
         end
      end else if (steps_ff != '0) begin
         rem_in   = ge ? DIVR_W'(rem_sh - {1'b0, divr_ff}) : rem_sh[DIVR_W-1:0];
         dvd_in   = {dvd_ff[DVD_W-2:0], ge};
         steps_in = steps_ff - STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ff <= '0;
      end else begin
         steps_ff <= steps_in;
      end
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      divr_ff <= divr_in;
   end

   assign busy     = steps_ff != '0;
   assign quotient = dvd_ff;

endmodule

[sv/kts_datapath.sv]
// Scroll state, touch and inertia update, bar geometry and result register.
// Depends on kts_pkg and kts_div.
module kts_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  kts_pkg::kts_cmd_type cmd,
   output kts_pkg::kts_stat_type stat,
   input  kts_pkg::kts_req_type req_data,
   input  logic                 csr_wr_en,
   input  logic [6:0]           csr_wr_data,
   output kts_pkg::kts_rsp_type rsp_data
);
   import kts_pkg::*;

   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [1:0]           ts_ff;
   logic [Y_W-1:0]       ty_ff;
   logic [COUNT_W-1:0]   eff;
   logic [CONTENT_W-1:0] content_ff, content_in;
   logic [CONTENT_W-1:0] max_off_ff, max_off_in;
   logic                 nz_ff;
   logic [OFFSET_W-1:0]  offset_ff, offset_in;
   logic signed [SPEED_W-1:0] speed_ff, speed_in;
   logic [Y_W-1:0]       prev_y_ff, prev_y_in;
   logic                 drag_ff, drag_in;
   logic [DRAWN_W-1:0]   drawn_ff, drawn_in;
   logic                 redraw_ff;
   logic [5:0]           fv_ff;
   logic [7:0]           len_ff;
   logic [DVD_W-1:0]     prod_ff;
   logic signed [SPEED_W-1:0] diff_y;
   logic [SPEED_W-1:0]   mag;
   logic [25:0]          decay_prod;
   logic [7:0]           mag_dec;
   logic [25:0]          fv_prod;
   logic [6:0]           fv_raw;
   logic [CONTENT_W-1:0] off_lim;
   logic                 shown;
   logic                 div_start;
   logic                 div_busy;
   logic [DVD_W-1:0]     div_dvd;
   logic [DIVR_W-1:0]    div_divr;
   logic [DVD_W-1:0]     quo;
   kts_rsp_type          rsp_ff;

   function automatic logic [OFFSET_W-1:0] clamp_offset(
      input logic signed [15:0] v,
      input logic [CONTENT_W-1:0] m
   );
      logic signed [15:0] r;
      r = v;
      if (v < 0) begin
         r = '0;
      end else if (v > $signed({2'b00, m})) begin
         r = $signed({2'b00, m});
      end
      return r[OFFSET_W-1:0];
   endfunction

   // bar limits from the list length
   always_comb begin
      eff        = (count_ff > CAP_CLIP) ? CAP_CLIP : count_ff;
      content_in = CONTENT_W'(eff) * PITCH;
      max_off_in = (content_in > VIEW) ? CONTENT_W'(content_in - VIEW) : '0;
   end

   // touch and inertia, item count write and drawn-offset mark
   always_comb begin
      diff_y     = $signed({1'b0, ty_ff}) - $signed({1'b0, prev_y_ff});
      mag        = speed_ff[SPEED_W-1] ? SPEED_W'(-speed_ff) : speed_ff;
      decay_prod = 26'(mag) * 26'(DECAY_MUL);
      mag_dec    = 8'(decay_prod >> DECAY_SH);
      count_in   = csr_wr_en ? csr_wr_data : count_ff;
      offset_in  = offset_ff;
      speed_in   = speed_ff;
      prev_y_in  = prev_y_ff;
      drag_in    = drag_ff;
      drawn_in   = drawn_ff;
      if (cmd.touch && nz_ff) begin
         if (ts_ff == TOUCH_PRESS) begin
            if (ty_ff >= HEADER) begin
               if (!drag_ff) begin
                  drag_in   = 1'b1;
                  prev_y_in = ty_ff;
                  speed_in  = '0;
               end else if (diff_y != 0) begin
                  offset_in = clamp_offset($signed({3'b000, offset_ff}) -
                                           {{7{diff_y[SPEED_W-1]}}, diff_y},
                                           max_off_ff);
                  prev_y_in = ty_ff;
                  speed_in  = -diff_y;
               end
            end
         end else begin
            drag_in = 1'b0;
         end
      end
      if (cmd.coast && nz_ff && !drag_ff && speed_ff != 0) begin
         offset_in = clamp_offset($signed({3'b000, offset_ff}) +
                                  {{7{speed_ff[SPEED_W-1]}}, speed_ff},
                                  max_off_ff);
         speed_in  = speed_ff[SPEED_W-1] ? -$signed({1'b0, mag_dec})
                                         : $signed({1'b0, mag_dec});
      end
      if (cmd.mark && nz_ff && {1'b0, offset_ff} != drawn_ff) begin
         drawn_in = {1'b0, offset_ff};
      end
   end

   always_comb begin
      fv_prod = 26'(offset_ff) * 26'(RECIP_PITCH);
      fv_raw  = 7'(fv_prod >> RECIP_PITCH_SH);
      off_lim = ({1'b0, offset_ff} > max_off_ff) ? max_off_ff : {1'b0, offset_ff};
      shown   = max_off_ff != '0;
   end

   // divider operands
   always_comb begin
      div_start = cmd.div_len_start | cmd.div_top_start;
      div_dvd   = cmd.div_len_start ? VIEW_SQ : prod_ff;
      div_divr  = cmd.div_len_start ? content_ff : max_off_ff;
   end

   kts_div u_div (
      .clock      (clock),
      .reset      (reset),
      .start      (div_start),
      .short_mode (cmd.div_len_start),
      .dividend   (div_dvd),
      .divisor    (div_divr),
      .busy       (div_busy),
      .quotient   (quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         offset_ff <= '0;
         speed_ff  <= '0;
         prev_y_ff <= '0;
         drag_ff   <= 1'b0;
         drawn_ff  <= DRAWN_NONE;
      end else begin
         count_ff  <= count_in;
         offset_ff <= offset_in;
         speed_ff  <= speed_in;
         prev_y_ff <= prev_y_in;
         drag_ff   <= drag_in;
         drawn_ff  <= drawn_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         ts_ff <= req_data.touch_state;
         ty_ff <= req_data.touch_y;
      end
      if (cmd.limits) begin
         content_ff <= content_in;
         max_off_ff <= max_off_in;
         nz_ff      <= eff != '0;
      end
      if (cmd.mark) begin
         redraw_ff <= nz_ff && ({1'b0, offset_ff} != drawn_ff);
         fv_ff     <= (fv_raw > 7'd63) ? 6'd63 : fv_raw[5:0];
      end
      if (cmd.take_len) begin
         len_ff <= (quo < DVD_W'(BAR_MIN)) ? BAR_MIN : quo[7:0];
      end
      if (cmd.prod) begin
         prod_ff <= DVD_W'(off_lim) * DVD_W'(VIEW_8 - len_ff);
      end
      if (cmd.load_rsp) begin
         rsp_ff.offset_now    <= offset_ff;
         rsp_ff.needs_redraw  <= redraw_ff;
         rsp_ff.drag_active   <= drag_ff;
         rsp_ff.first_visible <= fv_ff;
         rsp_ff.bar_shown     <= shown;
         rsp_ff.bar_top       <= shown ? 8'(HEADER + quo[7:0]) : HEADER;
         rsp_ff.bar_length    <= shown ? len_ff : 8'd0;
      end
   end

   assign stat.div_busy = div_busy;
   assign rsp_data      = rsp_ff;

endmodule

[sv/kts_ctrl.sv]
// Frame sequencer: steps the datapath through one frame and owns both handshakes.
// Depends on kts_pkg.
module kts_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  kts_pkg::kts_stat_type stat,
   output kts_pkg::kts_cmd_type  cmd
);
   import kts_pkg::*;

   kts_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_LIMITS;
            end
         end
         ST_LIMITS: begin
            cmd.limits = 1'b1;
            state_in   = ST_TOUCH;
         end
         ST_TOUCH: begin
            cmd.touch = 1'b1;
            state_in  = ST_COAST;
         end
         ST_COAST: begin
            cmd.coast         = 1'b1;
            cmd.div_len_start = 1'b1;
            state_in          = ST_MARK;
         end
         ST_MARK: begin
            cmd.mark = 1'b1;
            state_in = ST_WAIT_LEN;
         end
         ST_WAIT_LEN: begin
            if (!stat.div_busy) begin
               cmd.take_len = 1'b1;
               state_in     = ST_PROD;
            end
         end
         ST_PROD: begin
            cmd.prod = 1'b1;
            state_in = ST_TOP_START;
         end
         ST_TOP_START: begin
            cmd.div_top_start = 1'b1;
            state_in          = ST_WAIT_TOP;
         end
         ST_WAIT_TOP: begin
            if (!stat.div_busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[sv/kinetic_touch_scroll.sv]
// Kinetic touch scroll: one result per display frame, transferred into the output
// register; the next frame is taken in the cycle after that transfer. One frame at
// a time. The shared bit-serial divider runs 16 steps for bar length and 22 for
// bar top. The output register lets a new frame in while a result waits.
// Synchronous active-high reset: offset, speed, drag and item count clear, drawn
// offset goes to all ones; no clearing pass.
module kinetic_touch_scroll (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  kts_pkg::kts_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output kts_pkg::kts_rsp_type rsp_data,
   input  logic                 csr_wr_en,
   input  logic [6:0]           csr_wr_data
);
   import kts_pkg::*;

   // controller to datapath: one strobe per frame step
   kts_cmd_type  cmd;
   // datapath to controller: divider still running
   kts_stat_type stat;

   // Sequence per frame: capture, list limits, touch update, inertia (and
   // bar-length divide kick-off), redraw mark and first card, bar length taken,
   // bar-top product, bar-top divide, result transfer into the output register.
   kts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Item count register lives in the datapath; to be written only between frames.
   kts_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_data    (rsp_data)
   );

endmodule

[sv/kts_checker.sv]
// Port-level checks for the kinetic touch scroll top level, with its bind.
// Depends on kts_pkg and assert_macros.svh.
`include "assert_macros.svh"

module kts_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input kts_pkg::kts_rsp_type rsp_data
);
   import kts_pkg::*;

   logic req_take;
   logic rsp_wait;
   logic bar_hidden;
   logic bar_hidden_ok;
   logic bar_drawn;
   assign req_take      = req_valid && req_ready;
   assign rsp_wait      = rsp_valid && !rsp_ready;
   assign bar_hidden    = rsp_valid && !rsp_data.bar_shown;
   assign bar_hidden_ok = rsp_data.bar_top == HEADER && rsp_data.bar_length == 8'd0;
   assign bar_drawn     = rsp_valid && rsp_data.bar_shown;

   // a waiting result holds
   `KTS_ASSERT(a_rsp_hold, clock, reset, rsp_wait |=> rsp_valid && $stable(rsp_data))
   // one frame at a time
   `KTS_ASSERT(a_busy_after_take, clock, reset, req_take |=> !req_ready)
   // hidden bar reads as top 30, length 0
   `KTS_ASSERT(a_bar_hidden, clock, reset, bar_hidden |-> bar_hidden_ok)
   // drawn bar never shorter than the minimum
   `KTS_ASSERT(a_bar_min, clock, reset, bar_drawn |-> rsp_data.bar_length >= BAR_MIN)
   // reset empties the output and opens the input
   `KTS_ASSERT_ALWAYS(a_reset_state, clock, reset |=> !rsp_valid && req_ready)

endmodule

bind kinetic_touch_scroll kts_checker u_kts_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

[sim/kinetic_touch_scroll_tb.sv]
// Self-checking testbench for kinetic_touch_scroll: drag, fling, coast and scrollbar.
// Depends on kts_pkg for the frame and result types and on the block's RTL.
module kinetic_touch_scroll_tb;
   import kts_pkg::*;

   // Touch codes beyond the press code that the package gives
   localparam logic [1:0] TOUCH_NONE    = 2'd0;
   localparam logic [1:0] TOUCH_RELEASE = 2'd2;
   localparam logic [1:0] TOUCH_UNUSED  = 2'd3;

   // Velocity decay per coasting frame: v * 23 / 25, toward zero
   localparam int DECAY_NUM = 23;
   localparam int DECAY_DEN = 25;

   // Settle time covers one frame's work with a little margin on top
   localparam int SETTLE_CYCLES = 60;
   localparam int LONG_GAP      = 60;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_ready;
   kts_req_type req_data    = '0;
   logic        rsp_valid;
   logic        rsp_ready   = 1'b0;
   kts_rsp_type rsp_data;
   logic        csr_wr_en   = 1'b0;
   logic [6:0]  csr_wr_data = '0;

   // Scroll state as the block should hold it
   logic [6:0]  card_count  = '0;
   logic [12:0] scroll_pos  = '0;
   int          fling_speed = 0;
   logic [7:0]  last_y      = '0;
   bit          dragging    = 1'b0;
   logic [13:0] shown_pos   = '1;   // nothing drawn yet

   kts_rsp_type frames_due[$];       // results owed, oldest first
   int          err_cnt     = 0;
   int          sent_frames = 0;
   int          idle_pct    = 0;     // sender idles this many cycles in a hundred
   int          stall_pct   = 0;     // receiver stalls this many cycles in a hundred
   int          sweep_dir   = 1;     // gestures tend to keep scrolling one way

   kinetic_touch_scroll i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------
   // Scroll arithmetic
   // ---------------------------------------------------------------

   // Cards beyond the list capacity are not counted
   function automatic int cards_used();
      return (card_count > LIST_CAPACITY) ? LIST_CAPACITY : int'(card_count);
   endfunction

   // Furthest the list can scroll; zero when all cards fit in view
   function automatic int scroll_limit();
      int span;
      span = cards_used() * int'(PITCH) - int'(VIEW);
      return (span > 0) ? span : 0;
   endfunction

   // Offset updates always clamp to the current range
   function automatic logic [12:0] clamp_scroll(int v);
      int lim;
      lim = scroll_limit();
      if (v < 0)
         v = 0;
      else if (v > lim)
         v = lim;
      return 13'(v);
   endfunction

   // Advance the scroll state by one frame and give the result it should produce
   function automatic kts_rsp_type predict_frame(kts_req_type f);
      int          cards;
      int          lim;
      int          step;
      int          mag;
      int          len;
      int          pos;
      kts_rsp_type r;
      cards = cards_used();
      r     = '0;
      // An empty list freezes everything, drag flag included
      if (cards != 0) begin
         if (f.touch_state == TOUCH_PRESS) begin
            // Presses in the header strip are ignored outright
            if (f.touch_y >= HEADER) begin
               if (!dragging) begin
                  dragging    = 1'b1;
                  last_y      = f.touch_y;
                  fling_speed = 0;
               end else begin
                  step = int'(f.touch_y) - int'(last_y);
                  if (step != 0) begin
                     scroll_pos  = clamp_scroll(int'(scroll_pos) - step);
                     last_y      = f.touch_y;
                     fling_speed = -step;
                  end
               end
            end
         end else begin
            // release, no touch and the unused code all end a drag
            dragging = 1'b0;
         end
         if (!dragging && fling_speed != 0) begin
            scroll_pos  = clamp_scroll(int'(scroll_pos) + fling_speed);
            mag         = (fling_speed < 0) ? -fling_speed : fling_speed;
            mag         = mag * DECAY_NUM / DECAY_DEN;
            fling_speed = (fling_speed < 0) ? -mag : mag;
         end
         if ({1'b0, scroll_pos} != shown_pos) begin
            r.needs_redraw = 1'b1;
            shown_pos      = {1'b0, scroll_pos};
         end
      end
      r.offset_now    = scroll_pos;
      r.drag_active   = dragging;
      r.first_visible = (int'(scroll_pos) / int'(PITCH) > 63) ?
                        6'd63 : 6'(int'(scroll_pos) / int'(PITCH));
      lim = scroll_limit();
      if (lim > 0) begin
         len = int'(VIEW_SQ) / (cards * int'(PITCH));
         if (len < int'(BAR_MIN))
            len = int'(BAR_MIN);
         // a stale offset beyond the limit pins the bar at the bottom
         pos = (int'(scroll_pos) > lim) ? lim : int'(scroll_pos);
         r.bar_shown  = 1'b1;
         r.bar_top    = 8'(int'(HEADER) + pos * (int'(VIEW) - len) / lim);
         r.bar_length = 8'(len);
      end else begin
         r.bar_top = HEADER;
      end
      return r;
   endfunction

   // ---------------------------------------------------------------
   // Frame driver, result checker, receiver stalls
   // ---------------------------------------------------------------

   // Present one frame and hold it until the transfer; valid stays high afterwards
   // so a following call can go straight on, and settle() drops it.
   task automatic send_frame(logic [1:0] state, logic [7:0] y);
      kts_req_type f;
      f.touch_state = state;
      f.touch_y     = y;
      @(negedge clock);
      // now and then a long hole, so gaps land on every phase of the frame work
      if (idle_pct > 0 && $urandom_range(0, 9) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, LONG_GAP)) @(negedge clock);
      end
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = f;
      do
         @(posedge clock);
      while (!req_ready);
      frames_due.push_back(predict_frame(f));
      sent_frames++;
   endtask

   // Drop valid, wait for every owed result, then let the block go quiet
   task automatic settle();
      @(negedge clock);
      req_valid = 1'b0;
      while (frames_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Card count register; only written with the block idle
   task automatic set_count(logic [6:0] n);
      settle();
      csr_wr_en   = 1'b1;
      csr_wr_data = n;
      @(negedge clock);
      csr_wr_en   = 1'b0;
      card_count  = n;
   endtask

   task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         err_cnt++;
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   always @(negedge clock) begin
      rsp_ready = ($urandom_range(0, 99) >= stall_pct);
   end

   always @(posedge clock) begin : check_results
      kts_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (frames_due.size() == 0) begin
            err_cnt++;
            $display("%0t: result with nothing expected, expected none, got %p",
                     $time, rsp_data);
         end else begin
            want = frames_due.pop_front();
            check_field("offset_now",    16'(want.offset_now),
                        16'(rsp_data.offset_now));
            check_field("needs_redraw",  16'(want.needs_redraw),
                        16'(rsp_data.needs_redraw));
            check_field("drag_active",   16'(want.drag_active),
                        16'(rsp_data.drag_active));
            check_field("first_visible", 16'(want.first_visible),
                        16'(rsp_data.first_visible));
            check_field("bar_shown",     16'(want.bar_shown),
                        16'(rsp_data.bar_shown));
            check_field("bar_top",       16'(want.bar_top),
                        16'(rsp_data.bar_top));
            check_field("bar_length",    16'(want.bar_length),
                        16'(rsp_data.bar_length));
         end
      end
   end

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------

   // Straight after reset the list is empty: frames must leave the state alone
   task automatic test_empty_list();
      send_frame(TOUCH_PRESS, 8'd100);
      send_frame(TOUCH_RELEASE, 8'd0);
      send_frame(TOUCH_UNUSED, 8'd255);
   endtask

   // Header presses, drag start, clamp at the top, drag back, finger still
   task automatic test_drag_and_header();
      set_count(7'd64);
      send_frame(TOUCH_PRESS, 8'd0);     // header, but first frame drawn
      send_frame(TOUCH_PRESS, 8'd29);    // last header row
      send_frame(TOUCH_PRESS, 8'd30);    // first row below: drag starts
      send_frame(TOUCH_PRESS, 8'd239);   // pulls down past the top, clamps to 0
      send_frame(TOUCH_PRESS, 8'd100);   // pushes up 139 px
      send_frame(TOUCH_PRESS, 8'd100);   // no motion, speed kept
      send_frame(TOUCH_PRESS, 8'd10);    // header press mid-drag: ignored
      send_frame(TOUCH_RELEASE, 8'd10);  // lift off, coasting starts
   endtask

   // Inertia keeps going through idle codes and header presses
   task automatic test_coast();
      send_frame(TOUCH_NONE, 8'd0);
      send_frame(TOUCH_UNUSED, 8'd255);
      send_frame(TOUCH_PRESS, 8'd5);
      send_frame(TOUCH_NONE, 8'd0);
      // hold off until the block has answered everything
      settle();
   endtask

   // Oversized count clips to capacity; a fling runs into the bottom stop
   task automatic test_count_extremes();
      set_count(7'd127);
      send_frame(TOUCH_NONE, 8'd0);
      set_count(7'd10);
      send_frame(TOUCH_PRESS, 8'd239);
      send_frame(TOUCH_PRESS, 8'd30);
      send_frame(TOUCH_RELEASE, 8'd30);
      send_frame(TOUCH_NONE, 8'd0);
      send_frame(TOUCH_NONE, 8'd0);
   endtask

   // Shrinking the list leaves the offset past the new limit
   task automatic test_stale_offset();
      set_count(7'd3);
      send_frame(TOUCH_NONE, 8'd0);
      set_count(7'd2);                   // everything fits: no bar
      send_frame(TOUCH_NONE, 8'd0);
      set_count(7'd0);
      send_frame(TOUCH_PRESS, 8'd200);
   endtask

   // One finger stroke: press, a run of moves, lift, then some coasting frames
   task automatic play_gesture();
      int y;
      int moves;
      int coast;
      y = $urandom_range(30, 239);
      if ($urandom_range(0, 3) == 0)
         sweep_dir = -sweep_dir;
      send_frame(TOUCH_PRESS, 8'(y));
      moves = $urandom_range(1, 10);
      repeat (moves) begin
         case ($urandom_range(0, 9))
            0: begin
               send_frame(TOUCH_PRESS, 8'(y));
            end
            1: begin
               send_frame(TOUCH_PRESS, 8'($urandom_range(0, 29)));
            end
            default: begin
               y = y + sweep_dir * int'($urandom_range(0, 70));
               if (y > 239) begin
                  y = 239;
               end else if (y < 30) begin
                  y = 30;
               end
               send_frame(TOUCH_PRESS, 8'(y));
            end
         endcase
      end
      send_frame(($urandom_range(0, 3) == 0) ? TOUCH_NONE : TOUCH_RELEASE, 8'($urandom));
      coast = $urandom_range(0, 20);
      repeat (coast)
         send_frame(($urandom_range(0, 4) == 0) ? TOUCH_UNUSED : TOUCH_NONE, 8'($urandom));
   endtask

   // Mostly well-formed strokes, some raw noise, across counts and idling modes
   task automatic test_random();
      logic [6:0] seg_count[8]  = '{7'd64, 7'd3, 7'd127, 7'd12, 7'd0, 7'd2, 7'd40, 7'd64};
      int         seg_frames[8] = '{260, 220, 220, 220, 40, 80, 220, 260};
      int         send_gap[4]   = '{0, 84, 0, 14};
      int         recv_stall[4] = '{0, 0, 84, 14};
      int         seg;
      int         target;
      for (seg = 0; seg < 8; seg++) begin
         set_count(seg_count[seg]);
         idle_pct  = send_gap[seg % 4];
         stall_pct = recv_stall[seg % 4];
         target    = sent_frames + seg_frames[seg];
         while (sent_frames < target) begin
            if ($urandom_range(0, 9) < 8)
               play_gesture();
            else
               send_frame(2'($urandom), 8'($urandom));
         end
      end
      idle_pct  = 0;
      stall_pct = 0;
   endtask

   initial begin
      repeat (4) @(negedge clock);
      reset = 1'b0;
      test_empty_list();
      test_drag_and_header();
      test_coast();
      test_count_extremes();
      test_stale_offset();
      test_random();
      settle();
      if (err_cnt == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // Watchdog, far beyond the slowest legal run
   initial begin
      #8000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

[sim.f]
+incdir+sv
sv/kts_pkg.sv
sv/kts_div.sv
sv/kts_datapath.sv
sv/kts_ctrl.sv
sv/kinetic_touch_scroll.sv
sv/kts_checker.sv
sim/kinetic_touch_scroll_tb.sv
